// ===== design/plt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg
// Shared codes for the positional list table: operation modes, result
// status codes and the per-cell shift command.
// ----------------------------------------------------------------------------
package plt_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_GET    = 3'd3,
    MODE_FIND   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

endpackage
`default_nettype wire

// ===== design/plt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_cell
// One list slot. Holds a word, shifts from its neighbor on insert/remove,
// and flags a match or a positional select for find/get.
// ----------------------------------------------------------------------------
module plt_cell import plt_pkg::*; #(
  parameter int WORD_WIDTH = 32,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire cell_op_t              op,
  input  wire logic [CNT_W-1:0]      pos,
  input  wire logic [CNT_W-1:0]      cnt,
  input  wire logic [WORD_WIDTH-1:0] key,
  input  wire logic [WORD_WIDTH-1:0] left_word,
  input  wire logic [WORD_WIDTH-1:0] right_word,
  output logic      [WORD_WIDTH-1:0] word,
  output logic                       match,
  output logic      [WORD_WIDTH-1:0] sel_word
);

  localparam logic [CNT_W:0] SELF_IDX = (CNT_W + 1)'(INDEX);
  localparam logic [CNT_W:0] NEXT_IDX = (CNT_W + 1)'(INDEX + 1);

  logic [CNT_W:0]      pos_x;
  logic [CNT_W:0]      cnt_x;
  logic [WORD_WIDTH-1:0] word_next;

  assign pos_x = {1'b0, pos};
  assign cnt_x = {1'b0, cnt};

  always_comb begin
    word_next = word;
    unique case (op)
      CELL_INSERT: begin
        if (SELF_IDX == pos_x) begin
          word_next = key;
        end else if (SELF_IDX > pos_x && SELF_IDX <= cnt_x) begin
          word_next = left_word;
        end
      end
      CELL_REMOVE: begin
        if (SELF_IDX >= pos_x && NEXT_IDX < cnt_x) begin
          word_next = right_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign match    = (SELF_IDX < cnt_x) && (word == key);
  assign sel_word = (SELF_IDX == pos_x) ? word : '0;

endmodule
`default_nettype wire

// ===== design/positional_list_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_table
// Ordered list of words with append, insert, remove, get and find.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, one word each. Insert and
// remove shift every affected cell from its neighbor in the same cycle, and
// find compares all cells against the key at once, so the block takes one
// beat per cycle while input stall is low. A result passes through the
// capture register, which takes the cell match flags and the selected word,
// and then the output register, into which the first hit is encoded. Input
// stall rises only when the capture stage and the output register are both
// full and the output is stalled. Full, out-of-range and miss cases report
// a status and leave the list untouched. No clearing pass is needed after
// reset: only entries below the length are ever read.
// ----------------------------------------------------------------------------
module positional_list_table import plt_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beat
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [5:0]  position,
  input  wire logic [31:0] value,
  // result beat
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_value,
  output logic [5:0]       found_index,
  output logic [6:0]       list_length,
  output status_t          status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  // position is compared in a width that holds both the port and the count
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  // list length
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // cell chain
  cell_op_t              cell_op;
  logic [CNT_W-1:0]      cell_pos;
  logic [WORD_WIDTH-1:0] key;
  logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
  logic [WORD_WIDTH-1:0] cell_sel  [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;

  // decode of the accepted beat
  logic             in_acc;
  logic             full;
  logic             pos_le_cnt;
  logic             pos_lt_cnt;
  logic             do_insert;
  logic             do_remove;
  status_t          acc_status;
  logic [WORD_WIDTH-1:0] sel_or;

  // capture stage
  logic                  s_valid;
  logic                  s_adv;
  logic                  s_find;
  status_t               s_status;
  logic [CNT_W-1:0]      s_len;
  logic [CAPACITY-1:0]   s_match;
  logic [WORD_WIDTH-1:0] s_rd;

  // first-hit encode
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [63:0]      rd_wide;

  assign key = WORD_WIDTH'(value);

  assign s_adv    = !out_valid || !out_stall;
  assign in_stall = s_valid && !s_adv;
  assign in_acc   = in_valid && !in_stall;

  assign full       = (count == CNT_W'(CAPACITY));
  assign pos_le_cnt = CMP_W'(position) <= CMP_W'(count);
  assign pos_lt_cnt = CMP_W'(position) <  CMP_W'(count);

  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    acc_status = ST_OK;
    unique case (mode)
      MODE_APPEND: begin
        if (full) begin
          acc_status = ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      MODE_INSERT: begin
        if (full) begin
          acc_status = ST_FULL;
        end else if (!pos_le_cnt) begin
          acc_status = ST_RANGE;
        end else begin
          do_insert = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (!pos_lt_cnt) begin
          acc_status = ST_RANGE;
        end else begin
          do_remove = 1'b1;
        end
      end
      MODE_GET: begin
        if (!pos_lt_cnt) begin
          acc_status = ST_RANGE;
        end
      end
      default: begin
        acc_status = ST_OK;
      end
    endcase
  end

  // append is an insert at the current length
  assign cell_pos = (mode == MODE_APPEND) ? count : CNT_W'(position);

  always_comb begin
    cell_op = CELL_HOLD;
    if (in_acc && do_insert) begin
      cell_op = CELL_INSERT;
    end else if (in_acc && do_remove) begin
      cell_op = CELL_REMOVE;
    end
  end

  always_comb begin
    count_next = count;
    if (in_acc && do_insert) begin
      count_next = count + 1'b1;
    end else if (in_acc && do_remove) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // chain of cells; the ends see zero neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end

    plt_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .pos        (cell_pos),
      .cnt        (count),
      .key        (key),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .match      (cell_match[i]),
      .sel_word   (cell_sel[i])
    );
  end

  // at most one cell selects its word, so an OR picks it out
  always_comb begin
    sel_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_or = sel_or | cell_sel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_acc) begin
      s_valid <= 1'b1;
    end else if (s_adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_find   <= (mode == MODE_FIND);
      s_status <= acc_status;
      s_len    <= count_next;
      s_match  <= (mode == MODE_FIND) ? cell_match : '0;
      s_rd     <= (mode == MODE_GET && acc_status == ST_OK) ? sel_or : '0;
    end
  end

  // lowest matching cell wins
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (s_match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit     = |s_match;
  assign rd_wide = 64'(s_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_valid && s_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_adv) begin
      read_value  <= rd_wide[31:0];
      found_index <= hit ? 6'(hit_idx) : 6'd0;
      list_length <= 7'(s_len);
      status      <= (s_find && !hit) ? ST_MISS : s_status;
    end
  end

  // length never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  // a rejected append leaves the length alone
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (in_acc && mode == MODE_APPEND && full) |=> count == $past(count))
    else $error("length changed on full append");

  // capture stage is held while the output is blocked
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while result path blocked");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_MISS) |-> found_index == 6'd0)
    else $error("nonzero index on find miss");

endmodule
`default_nettype wire
